// ===== src/ppfp_pkg.sv =====
// Shared types, constants and helper functions for the pointing pad frame processor.
// Used by ppfp_mul_unit and pointing_pad_frame_processor_unit; depends on nothing else.
`default_nettype none

package ppfp_pkg;

	// shared multiplier geometry
	localparam int MUL_A_W   = 16;
	localparam int MUL_B_W   = 21;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_R_W   = 18;
	// every constant division is a multiply by a rounded-up reciprocal, then this shift
	localparam int DIV_SHIFT = 22;

	typedef logic [MUL_A_W-1:0] mul_a_t;
	typedef logic [MUL_B_W-1:0] mul_b_t;
	typedef logic [MUL_P_W-1:0] mul_p_t;
	typedef logic [MUL_R_W-1:0] mul_r_t;

	typedef struct packed {
		mul_a_t a;
		mul_b_t b;
		logic   div;
	} mul_op_t;

	// ceil(2^DIV_SHIFT / k); exact floor for the operand ranges used here
	localparam mul_b_t RECIP_3  = mul_b_t'(((1 << DIV_SHIFT) + 2) / 3);
	localparam mul_b_t RECIP_6  = mul_b_t'(((1 << DIV_SHIFT) + 5) / 6);
	localparam mul_b_t RECIP_7  = mul_b_t'(((1 << DIV_SHIFT) + 6) / 7);
	localparam mul_b_t RECIP_9  = mul_b_t'(((1 << DIV_SHIFT) + 8) / 9);
	localparam mul_b_t RECIP_48 = mul_b_t'(((1 << DIV_SHIFT) + 47) / 48);

	// divide by 48*48 = 256 * 9: shift first, then reciprocal of 9
	localparam int SQ_PRE_SHIFT = 8;

	localparam mul_b_t MIN_SCALE = mul_b_t'(7);
	localparam mul_b_t THR_SCALE = mul_b_t'(6);
	localparam mul_b_t DITH_SCALE = mul_b_t'(10);

	localparam logic [7:0] TOUCH_HI_MASK = 8'h7c;
	localparam logic [7:0] CENTER_POS    = 8'h80;
	localparam logic [7:0] DEAD_PLAY     = 8'd36;
	localparam logic [7:0] HALF_KNEE     = 8'd24;
	localparam logic [8:0] KNEE          = 9'd48;
	localparam logic [7:0] SAT_LIMIT     = 8'd128;
	localparam logic [7:0] SAT_MAX       = 8'd127;
	localparam logic [3:0] TICK_MAX      = 4'd10;

	localparam logic [2:0] GAIN_NORMAL [4] = '{3'd3, 3'd4, 3'd5, 3'd6};
	localparam logic [2:0] GAIN_AIM    [4] = '{3'd2, 3'd2, 3'd3, 3'd3};

	function automatic logic [2:0] gain_sel(input logic aim_mode, input logic [1:0] sens);
		return aim_mode ? GAIN_AIM[sens] : GAIN_NORMAL[sens];
	endfunction

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? (b - a) : (a - b);
	endfunction

endpackage

`default_nettype wire

// ===== src/pointing_pad_frame_processor_unit.sv =====
// Top level of the pointing pad frame processor: byte parser, frame-end sequencer, result register.
// Depends on ppfp_pkg and ppfp_mul_unit.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-----------------------------
//   byte     | byte_in, aim                              | byte_valid / byte_stall
//   result   | frame_done, move_x, move_y, touched,      | result_valid / result_stall
//            | touch_level, touch_threshold, in_frame    |
//   cfg      | cfg_data (sensitivity)                    | cfg_valid / cfg_ready
//
// A byte that does not complete a frame is accepted, then published. The byte that
// completes a frame is accepted with the level filter, then takes 5 steps for the
// minimum and threshold (4 on the shared multiplier), then 1 to 9 steps per axis, then publish.
// byte_stall is high from accept until the result is loaded into the result register; a
// stalled result register holds the sequencer in publish. Reset is asynchronous, active low.
`default_nettype none

module pointing_pad_frame_processor_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire logic [7:0]        byte_in,
	input  wire logic              aim,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   frame_done,
	output logic signed [7:0]      move_x,
	output logic signed [7:0]      move_y,
	output logic                   touched,
	output logic [11:0]            touch_level,
	output logic [11:0]            touch_threshold,
	output logic                   in_frame,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_data
);

	typedef enum logic [15:0] {
		ST_IDLE = 16'h0001,
		ST_MIN7 = 16'h0002,
		ST_MIN6 = 16'h0004,
		ST_F6   = 16'h0008,
		ST_F7   = 16'h0010,
		ST_THR  = 16'h0020,
		ST_VG   = 16'h0040,
		ST_V3   = 16'h0080,
		ST_SQ   = 16'h0100,
		ST_D1   = 16'h0200,
		ST_CU   = 16'h0400,
		ST_D2   = 16'h0800,
		ST_MAG  = 16'h1000,
		ST_D3   = 16'h2000,
		ST_DITH = 16'h4000,
		ST_PUB  = 16'h8000
	} state_t;

	state_t state_q, state_d;

	// model state
	logic [2:0]  pos_q, pos_d;
	logic [11:0] rt_q, rt_d;
	logic [7:0]  rx_q, rx_d, ry_q, ry_d;
	logic [11:0] fl_q, fl_d, thr_q, thr_d, min_q, min_d;
	logic [7:0]  cx_q, cx_d, cy_q, cy_d;
	logic [7:0]  px_q, px_d, py_q, py_d;
	logic [3:0]  tick_q, tick_d;
	logic [7:0]  mx_q, mx_d, my_q, my_d;
	logic [1:0]  sens_q;

	// sequencer working registers
	logic        ax_q, ax_d;
	logic        done_q, done_d;
	logic        aim_q, aim_d;
	logic        upd_q, upd_d;
	logic        neg_q, neg_d;
	logic        big_q, big_d;
	logic [8:0]  vs_q, vs_d;

	// result register
	logic        out_valid_q;
	logic        out_load;
	logic        done_out_q, touched_out_q, frame_out_q;
	logic [7:0]  mx_out_q, my_out_q;
	logic [11:0] fl_out_q, thr_out_q;

	ppfp_pkg::mul_op_t op;
	ppfp_pkg::mul_r_t  r;

	logic [2:0]  pos_eff;
	logic [11:0] f_new, min_eff, thr_eff;
	logic        near, recenter;
	logic [7:0]  raw_sel, ctr_sel, dv, mag, mv;
	logic [2:0]  gain;
	logic        axis_fin;

	ppfp_mul_unit u_mul (
		.clk (clk),
		.op  (op),
		.res (r)
	);

	assign pos_eff = byte_in[7] ? 3'd1 : pos_q;
	assign f_new   = fl_q - {2'b00, fl_q[11:2]} + {2'b00, rt_q[11:2]};
	assign min_eff = (fl_q < min_q) ? fl_q : min_q;
	assign thr_eff = upd_q ? r[11:0] : thr_q;
	assign near    = (ppfp_pkg::abs_diff(rx_q, ppfp_pkg::CENTER_POS) < ppfp_pkg::DEAD_PLAY) &&
	                 (ppfp_pkg::abs_diff(ry_q, ppfp_pkg::CENTER_POS) < ppfp_pkg::DEAD_PLAY);
	// re-center only while untouched, near the middle (or never centered), and steady
	assign recenter = (thr_eff < fl_q) && (near || (cx_q == 8'd0 && cy_q == 8'd0)) &&
	                  (rx_q == px_q) && (ry_q == py_q);
	assign raw_sel = ax_q ? ry_q : rx_q;
	assign ctr_sel = ax_q ? cy_q : cx_q;
	assign dv      = ppfp_pkg::abs_diff(raw_sel, ctr_sel);
	assign gain    = ppfp_pkg::gain_sel(aim_q, sens_q);
	assign mv      = neg_q ? (~mag + 8'd1) : mag;

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		rt_d     = rt_q;
		rx_d     = rx_q;
		ry_d     = ry_q;
		fl_d     = fl_q;
		thr_d    = thr_q;
		min_d    = min_q;
		cx_d     = cx_q;
		cy_d     = cy_q;
		px_d     = px_q;
		py_d     = py_q;
		tick_d   = tick_q;
		mx_d     = mx_q;
		my_d     = my_q;
		ax_d     = ax_q;
		done_d   = done_q;
		aim_d    = aim_q;
		upd_d    = upd_q;
		neg_d    = neg_q;
		big_d    = big_q;
		vs_d     = vs_q;
		op       = '0;
		mag      = 8'd0;
		axis_fin = 1'b0;
		out_load = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (byte_valid) begin
					done_d  = 1'b0;
					state_d = ST_PUB;
					unique case (pos_eff)
						3'd1: begin
							rt_d  = {byte_in[6:2] & ppfp_pkg::TOUCH_HI_MASK[6:2], 7'd0};
							ry_d  = {byte_in[1], 7'd0};
							rx_d  = {byte_in[0], 7'd0};
							pos_d = 3'd2;
						end
						3'd2: begin
							rt_d  = rt_q | {4'd0, byte_in};
							pos_d = 3'd3;
						end
						3'd3: begin
							rx_d  = rx_q | byte_in;
							pos_d = 3'd4;
						end
						3'd4: begin
							ry_d    = ry_q | byte_in;
							pos_d   = 3'd0;
							fl_d    = f_new;
							aim_d   = aim;
							done_d  = 1'b1;
							state_d = ST_MIN7;
						end
						default: begin
							pos_d = 3'd0;
						end
					endcase
				end
			end
			ST_MIN7: begin
				min_d   = min_eff;
				op.a    = ppfp_pkg::mul_a_t'(min_eff);
				op.b    = ppfp_pkg::MIN_SCALE;
				state_d = ST_MIN6;
			end
			ST_MIN6: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::RECIP_6;
				op.div  = 1'b1;
				state_d = ST_F6;
			end
			ST_F6: begin
				upd_d   = r < ppfp_pkg::mul_r_t'(fl_q);
				op.a    = ppfp_pkg::mul_a_t'(fl_q);
				op.b    = ppfp_pkg::THR_SCALE;
				state_d = ST_F7;
			end
			ST_F7: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::RECIP_7;
				op.div  = 1'b1;
				state_d = ST_THR;
			end
			ST_THR: begin
				if (upd_q) begin
					thr_d = r[11:0];
					min_d = r[11:0];
				end
				if (recenter) begin
					cx_d = rx_q;
					cy_d = ry_q;
				end
				ax_d    = 1'b0;
				state_d = ST_VG;
			end
			ST_VG: begin
				neg_d = raw_sel < ctr_sel;
				if (dv < ppfp_pkg::HALF_KNEE) begin
					axis_fin = 1'b1;
				end else begin
					op.a    = ppfp_pkg::mul_a_t'(dv);
					op.b    = ppfp_pkg::mul_b_t'(gain);
					state_d = ST_V3;
				end
			end
			ST_V3: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::RECIP_3;
				op.div  = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				vs_d    = r[8:0];
				big_d   = r >= ppfp_pkg::mul_r_t'(ppfp_pkg::KNEE);
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::mul_b_t'(r);
				state_d = ST_D1;
			end
			ST_D1: begin
				if (big_q) begin
					op.a = ppfp_pkg::mul_a_t'(r >> ppfp_pkg::SQ_PRE_SHIFT);
					op.b = ppfp_pkg::RECIP_9;
				end else begin
					op.a = ppfp_pkg::mul_a_t'(r);
					op.b = ppfp_pkg::RECIP_48;
				end
				op.div  = 1'b1;
				state_d = ST_CU;
			end
			ST_CU: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::mul_b_t'(vs_q);
				state_d = ST_D2;
			end
			ST_D2: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::RECIP_48;
				op.div  = 1'b1;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				if (big_q) begin
					mag      = (r >= ppfp_pkg::mul_r_t'(ppfp_pkg::SAT_LIMIT)) ?
					           ppfp_pkg::SAT_MAX : {1'b0, r[6:0]};
					axis_fin = 1'b1;
				end else begin
					op.a    = ppfp_pkg::mul_a_t'(r);
					op.b    = ppfp_pkg::DITH_SCALE;
					state_d = ST_D3;
				end
			end
			ST_D3: begin
				op.a    = ppfp_pkg::mul_a_t'(r);
				op.b    = ppfp_pkg::RECIP_48;
				op.div  = 1'b1;
				state_d = ST_DITH;
			end
			ST_DITH: begin
				// small motion: one count whenever the tick has not passed the cubic value
				mag      = (ppfp_pkg::mul_r_t'(tick_q) <= r) ? 8'd1 : 8'd0;
				axis_fin = 1'b1;
			end
			ST_PUB: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (axis_fin) begin
			if (!ax_q) begin
				mx_d    = mv;
				ax_d    = 1'b1;
				state_d = ST_VG;
			end else begin
				my_d    = mv;
				px_d    = rx_q;
				py_d    = ry_q;
				tick_d  = (tick_q >= ppfp_pkg::TICK_MAX) ? 4'd0 : tick_q + 4'd1;
				state_d = ST_PUB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			rt_q        <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			fl_q        <= '0;
			thr_q       <= '0;
			min_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			px_q        <= '0;
			py_q        <= '0;
			tick_q      <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			ax_q        <= 1'b0;
			done_q      <= 1'b0;
			sens_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			rt_q    <= rt_d;
			rx_q    <= rx_d;
			ry_q    <= ry_d;
			fl_q    <= fl_d;
			thr_q   <= thr_d;
			min_q   <= min_d;
			cx_q    <= cx_d;
			cy_q    <= cy_d;
			px_q    <= px_d;
			py_q    <= py_d;
			tick_q  <= tick_d;
			mx_q    <= mx_d;
			my_q    <= my_d;
			ax_q    <= ax_d;
			done_q  <= done_d;
			if (cfg_valid) begin
				sens_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		aim_q <= aim_d;
		upd_q <= upd_d;
		neg_q <= neg_d;
		big_q <= big_d;
		vs_q  <= vs_d;
		if (out_load) begin
			done_out_q    <= done_q;
			mx_out_q      <= mx_q;
			my_out_q      <= my_q;
			touched_out_q <= (fl_q < thr_q) || (mx_q != 8'd0) || (my_q != 8'd0);
			fl_out_q      <= fl_q;
			thr_out_q     <= thr_q;
			frame_out_q   <= pos_q != 3'd0;
		end
	end

	assign byte_stall      = (state_q != ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign result_valid    = out_valid_q;
	assign frame_done      = done_out_q;
	assign move_x          = mx_out_q;
	assign move_y          = my_out_q;
	assign touched         = touched_out_q;
	assign touch_level     = fl_out_q;
	assign touch_threshold = thr_out_q;
	assign in_frame        = frame_out_q;

	ap_done_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_done) |-> !in_frame)
		else $error("completed frame reported while still in frame");

	ap_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= ppfp_pkg::TICK_MAX)
		else $error("dither tick out of range");

	ap_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 3'd4)
		else $error("byte position out of range");

	ap_move_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (move_x != 8'sh80 && move_y != 8'sh80))
		else $error("movement outside saturation range");

endmodule

`default_nettype wire

// ===== src/ppfp_mul_unit.sv =====
// Shared multiplier with registered result and optional reciprocal post-shift.
// Depends on ppfp_pkg for operand types and the division shift.
`default_nettype none

module ppfp_mul_unit (
	input  wire logic              clk,
	input  wire ppfp_pkg::mul_op_t op,
	output ppfp_pkg::mul_r_t       res
);

	ppfp_pkg::mul_p_t prod;
	ppfp_pkg::mul_r_t res_q;

	assign prod = ppfp_pkg::mul_p_t'(op.a) * ppfp_pkg::mul_p_t'(op.b);

	always_ff @(posedge clk) begin
		if (op.div) begin
			res_q <= ppfp_pkg::mul_r_t'(prod >> ppfp_pkg::DIV_SHIFT);
		end else begin
			res_q <= ppfp_pkg::mul_r_t'(prod);
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== bench/pointing_pad_frame_processor_unit_test.sv =====
// Testbench for pointing_pad_frame_processor_unit: drives serial pad bytes and checks every
// result item against a built-in model of the frame parser, level filter and motion shaping.
// Depends only on the RTL: ppfp_pkg, ppfp_mul_unit and pointing_pad_frame_processor_unit.
module pointing_pad_frame_processor_unit_test;

	localparam int unsigned KNEE_DIST     = 48;
	localparam int unsigned DEAD_ZONE     = 24;
	localparam int unsigned REST_WINDOW   = 36;
	localparam int unsigned SAT_LIMIT     = 128;
	localparam int unsigned SAT_MAG       = 127;
	localparam int unsigned GAIN_DIVISOR  = 3;
	localparam int unsigned DITHER_SCALE  = 10;
	localparam logic [3:0]  DITHER_LAST   = 4'd10;
	localparam logic [7:0]  PAD_MIDPOINT  = 8'd128;
	localparam int unsigned NORMAL_GAIN [4] = '{3, 4, 5, 6};
	localparam int unsigned AIM_GAIN    [4] = '{2, 2, 3, 3};

	// next byte expected within a frame
	localparam logic [2:0] SLOT_IDLE   = 3'd0;
	localparam logic [2:0] SLOT_HEADER = 3'd1;
	localparam logic [2:0] SLOT_TOUCH  = 3'd2;
	localparam logic [2:0] SLOT_X      = 3'd3;
	localparam logic [2:0] SLOT_Y      = 3'd4;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PRINT_CAP     = 100;

	typedef struct {
		logic              frame_done;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic              touched;
		logic [11:0]       touch_level;
		logic [11:0]       touch_threshold;
		logic              in_frame;
	} pad_report_t;

	logic              clk;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [7:0]        byte_in;
	logic              aim;
	logic              result_valid;
	logic              result_stall;
	logic              frame_done;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic              touched;
	logic [11:0]       touch_level;
	logic [11:0]       touch_threshold;
	logic              in_frame;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_data;

	pointing_pad_frame_processor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_in(byte_in),
		.aim(aim),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.frame_done(frame_done),
		.move_x(move_x),
		.move_y(move_y),
		.touched(touched),
		.touch_level(touch_level),
		.touch_threshold(touch_threshold),
		.in_frame(in_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// pad model state
	logic [1:0]  pad_sens      = 2'd0;
	logic [2:0]  slot          = SLOT_IDLE;
	logic [11:0] raw_touch     = 12'd0;
	logic [7:0]  raw_x         = 8'd0;
	logic [7:0]  raw_y         = 8'd0;
	logic [11:0] pad_level     = 12'd0;
	logic [11:0] pad_threshold = 12'd0;
	logic [11:0] pad_minimum   = 12'd0;
	logic [7:0]  ctr_x         = 8'd0;
	logic [7:0]  ctr_y         = 8'd0;
	logic [7:0]  prev_x        = 8'd0;
	logic [7:0]  prev_y        = 8'd0;
	logic [3:0]  dither        = 4'd0;
	logic [7:0]  mv_x          = 8'd0;
	logic [7:0]  mv_y          = 8'd0;

	pad_report_t pending_reports [$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	logic        idling_on = 1'b1;
	logic        hold_off_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned axis_distance(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? int'(b - a) : int'(a - b);
	endfunction

	function automatic logic [7:0] axis_motion(input logic [7:0] pos, input logic [7:0] ctr,
			input logic aim_mode);
		int unsigned d, g, v, c, mag;
		logic [7:0] m8;
		d = axis_distance(pos, ctr);
		if (d < DEAD_ZONE)
			return 8'd0;
		g = aim_mode ? AIM_GAIN[pad_sens] : NORMAL_GAIN[pad_sens];
		v = d * g / GAIN_DIVISOR;
		if (v < KNEE_DIST) begin
			// cubic value below the knee only sets the odds of a single count
			c = ((((v * v) / KNEE_DIST) * v) / KNEE_DIST * DITHER_SCALE) / KNEE_DIST;
			mag = (dither <= c) ? 1 : 0;
		end else begin
			mag = ((v * v) / (KNEE_DIST * KNEE_DIST)) * v / KNEE_DIST;
			if (mag >= SAT_LIMIT)
				mag = SAT_MAG;
		end
		m8 = mag[7:0];
		return (pos < ctr) ? 8'(0 - m8) : m8;
	endfunction

	function automatic void close_pad_frame(input logic aim_mode);
		int unsigned cur, lim;
		cur = pad_level - (pad_level >> 2) + (raw_touch >> 2);
		pad_level = cur[11:0];
		if (pad_level < pad_minimum)
			pad_minimum = pad_level;
		lim = pad_minimum;
		if (lim * 7 / 6 < pad_level) begin
			cur = pad_level;
			cur = cur * 6 / 7;
			pad_threshold = cur[11:0];
			pad_minimum = pad_threshold;
		end
		// untouched, near the middle (or never centered) and steady: take the current position as the rest point
		if (pad_threshold < pad_level) begin
			if ((axis_distance(raw_x, PAD_MIDPOINT) < REST_WINDOW &&
					axis_distance(raw_y, PAD_MIDPOINT) < REST_WINDOW) ||
					(ctr_x == 8'd0 && ctr_y == 8'd0)) begin
				if (raw_x == prev_x && raw_y == prev_y) begin
					ctr_x = raw_x;
					ctr_y = raw_y;
				end
			end
		end
		mv_x = axis_motion(raw_x, ctr_x, aim_mode);
		mv_y = axis_motion(raw_y, ctr_y, aim_mode);
		prev_x = raw_x;
		prev_y = raw_y;
		dither = (dither >= DITHER_LAST) ? 4'd0 : dither + 4'd1;
	endfunction

	function automatic pad_report_t predict_pad_report(input logic [7:0] b, input logic aim_mode);
		pad_report_t r;
		logic done;
		done = 1'b0;
		if (b[7])
			slot = SLOT_HEADER;
		case (slot)
			SLOT_HEADER: begin
				raw_touch = {b[6:2], 7'd0};
				raw_y = {b[1], 7'd0};
				raw_x = {b[0], 7'd0};
				slot = SLOT_TOUCH;
			end
			SLOT_TOUCH: begin
				raw_touch = raw_touch | {4'd0, b};
				slot = SLOT_X;
			end
			SLOT_X: begin
				raw_x = raw_x | b;
				slot = SLOT_Y;
			end
			SLOT_Y: begin
				raw_y = raw_y | b;
				slot = SLOT_IDLE;
				close_pad_frame(aim_mode);
				done = 1'b1;
			end
			default: begin
				slot = SLOT_IDLE;
			end
		endcase
		r.frame_done = done;
		r.move_x = mv_x;
		r.move_y = mv_y;
		r.touched = (pad_level < pad_threshold) || mv_x != 8'd0 || mv_y != 8'd0;
		r.touch_level = pad_level;
		r.touch_threshold = pad_threshold;
		r.in_frame = (slot >= SLOT_HEADER);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		pad_report_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result item with none pending", frame_done, 0);
			end else begin
				want = pending_reports.pop_front();
				if (frame_done !== want.frame_done)
					report_mismatch("frame_done", frame_done, want.frame_done);
				if (move_x !== want.move_x)
					report_mismatch("move_x", move_x, want.move_x);
				if (move_y !== want.move_y)
					report_mismatch("move_y", move_y, want.move_y);
				if (touched !== want.touched)
					report_mismatch("touched", touched, want.touched);
				if (touch_level !== want.touch_level)
					report_mismatch("touch_level", touch_level, want.touch_level);
				if (touch_threshold !== want.touch_threshold)
					report_mismatch("touch_threshold", touch_threshold, want.touch_threshold);
				if (in_frame !== want.in_frame)
					report_mismatch("in_frame", in_frame, want.in_frame);
			end
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				for (n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_off_req = 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				result_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic aim_bit);
		int gap;
		if (idling_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) begin
				@(negedge clk);
				byte_valid <= 1'b0;
			end
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_in <= b;
		aim <= aim_bit;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		pending_reports.push_back(predict_pad_report(b, aim_bit));
		bytes_sent++;
	endtask

	// aim only matters on the last byte of a frame
	task automatic send_frame(input logic [11:0] lvl, input logic [7:0] x, input logic [7:0] y,
			input logic aim_bit);
		send_byte({1'b1, lvl[11:7], y[7], x[7]}, 1'($urandom_range(0, 1)));
		send_byte({1'b0, lvl[6:0]}, 1'($urandom_range(0, 1)));
		send_byte({1'b0, x[6:0]}, 1'($urandom_range(0, 1)));
		send_byte({1'b0, y[6:0]}, aim_bit);
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sensitivity(input logic [1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pad_sens = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_episode();
		int kind, n;
		logic [11:0] lvl;
		logic [7:0] x, y;
		kind = $urandom_range(0, 9);
		n = $urandom_range(2, 6);
		case (kind)
			0, 1, 2, 3: begin
				// touched: low level, motion around the rest point
				repeat (n)
					send_frame(12'($urandom_range(0, 1500)), 8'($urandom_range(60, 196)),
						8'($urandom_range(60, 196)), 1'($urandom_range(0, 1)));
			end
			4, 5, 6: begin
				// resting: high level, same position frame after frame
				lvl = 12'($urandom_range(2500, 4095));
				x = 8'($urandom_range(100, 156));
				y = 8'($urandom_range(100, 156));
				repeat (n)
					send_frame(lvl, x, y, 1'($urandom_range(0, 1)));
			end
			7: begin
				repeat (n)
					send_byte(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			end
			8: begin
				// frame cut short, the next header restarts
				send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 2))
					send_byte(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			end
			default: begin
				send_frame(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		endcase
	endtask

	task automatic test_directed_frames();
		write_sensitivity(2'd3);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_frame(12'h000, 8'd0, 8'd0, 1'b0);
		// two identical untouched frames at mid travel set the rest point
		send_frame(12'hfff, 8'd128, 8'd128, 1'b0);
		send_frame(12'hfff, 8'd128, 8'd128, 1'b0);
		send_byte(8'hff, 1'b0);
		send_frame(12'hfff, 8'd255, 8'd255, 1'b0);
		send_frame(12'h000, 8'd0, 8'd0, 1'b1);
		// small motion on x, dead zone on y
		send_frame(12'hfff, 8'd158, 8'd118, 1'b1);
		wait_until_drained();
	endtask

	task automatic test_sensitivity_sweep();
		int s;
		logic [7:0] x, y;
		for (s = 0; s < 4; s++) begin
			write_sensitivity(2'(s));
			x = 8'($urandom_range(100, 156));
			y = 8'($urandom_range(100, 156));
			send_frame(12'hfff, x, y, 1'b0);
			send_frame(12'hfff, x, y, 1'b1);
			repeat (8)
				send_frame(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			wait_until_drained();
		end
	endtask

	task automatic test_mixed_traffic();
		int chunk, stop_at;
		for (chunk = 0; chunk < 4; chunk++) begin
			write_sensitivity(2'($urandom_range(0, 3)));
			stop_at = bytes_sent + 260;
			while (bytes_sent < stop_at)
				send_episode();
			wait_until_drained();
		end
	endtask

	task automatic test_result_hold_off();
		hold_off_req = 1'b1;
		repeat (12)
			send_frame(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		wait_until_drained();
	endtask

	task automatic test_back_to_back_tail();
		int stop_at;
		write_sensitivity(2'd0);
		idling_on = 1'b0;
		stop_at = bytes_sent + 250;
		while (bytes_sent < stop_at)
			send_episode();
		wait_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_in = 8'd0;
		aim = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 2'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();
		test_sensitivity_sweep();
		test_mixed_traffic();
		test_result_hold_off();
		test_back_to_back_tail();

		if (pending_reports.size() != 0)
			report_mismatch("result items never delivered", pending_reports.size(), 0);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
